FILE: rtl/m3i_pkg.sv
// Shared widths, index names and pipeline payload types for the 3x3 inverse.
`default_nettype none
package m3i_pkg;

    localparam int DATA_W  = 24;
    localparam int LANES   = 9;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int LO_W    = DATA_W;
    localparam int PP_W    = COF_W;
    localparam int TERM_W  = 74;
    localparam int DET_W   = 75;
    localparam int MAG_W   = 74;
    localparam int CMAG_W  = PROD_W;
    localparam int FRAC_SH = 33;
    localparam int NUM_W   = CMAG_W + FRAC_SH + 1;
    localparam int DEN_W   = MAG_W + 1;
    localparam int QB      = 25;
    localparam int FRONT_STAGES = 8;

    localparam int XX = 0;
    localparam int XY = 1;
    localparam int XZ = 2;
    localparam int YX = 3;
    localparam int YY = 4;
    localparam int YZ = 5;
    localparam int ZX = 6;
    localparam int ZY = 7;
    localparam int ZZ = 8;

    localparam logic [DATA_W-1:0] Q_MAXPOS = 24'h7FFFFF;
    localparam logic [DATA_W-1:0] Q_MAXNEG = 24'h800000;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    qw;
        logic             big;
        logic             neg;
        logic             czero;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic [DEN_W-1:0]  den;
        logic              dzero;
    } div_t;

endpackage
`default_nettype wire

FILE: rtl/m3i_in_if.sv
// Input channel: one 3x3 matrix per transfer.
`default_nettype none
interface m3i_in_if;
    logic          valid;
    logic          ready;
    m3i_pkg::q_t   a_xx;
    m3i_pkg::q_t   a_xy;
    m3i_pkg::q_t   a_xz;
    m3i_pkg::q_t   a_yx;
    m3i_pkg::q_t   a_yy;
    m3i_pkg::q_t   a_yz;
    m3i_pkg::q_t   a_zx;
    m3i_pkg::q_t   a_zy;
    m3i_pkg::q_t   a_zz;

    modport source (output valid, a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz,
                    input ready);
    modport sink   (input valid, a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/m3i_out_if.sv
// Output channel: one inverse matrix and singular flag per transfer.
`default_nettype none
interface m3i_out_if;
    logic          valid;
    logic          ready;
    m3i_pkg::q_t   inv_xx;
    m3i_pkg::q_t   inv_xy;
    m3i_pkg::q_t   inv_xz;
    m3i_pkg::q_t   inv_yx;
    m3i_pkg::q_t   inv_yy;
    m3i_pkg::q_t   inv_yz;
    m3i_pkg::q_t   inv_zx;
    m3i_pkg::q_t   inv_zy;
    m3i_pkg::q_t   inv_zz;
    logic          singular;

    modport source (output valid, inv_xx, inv_xy, inv_xz, inv_yx, inv_yy, inv_yz,
                    inv_zx, inv_zy, inv_zz, singular, input ready);
    modport sink   (input valid, inv_xx, inv_xy, inv_xz, inv_yx, inv_yy, inv_yz,
                    inv_zx, inv_zy, inv_zz, singular, output ready);
endinterface
`default_nettype wire

FILE: rtl/matrix3_inverse.sv
// 3x3 matrix inverse by adjugate and rounded division, Q8.16 in and out.
//
// Usage: din carries one matrix (nine signed Q8.16 entries) per transfer;
// dout carries the nine inverse entries and the singular flag, one result
// per input, in input order.
// Pipeline from a din transfer to dout.valid: 8 setup stages,
// 25 division stages, one output register.
// Throughput: one matrix per cycle while dout is not stalled; every stage is
// a register with its own valid bit, and the 25 stages of the restoring divider
// each produce one quotient bit for all nine entries.
// Singular is set when the determinant is zero (all entries then zero) or
// when any entry saturates to the Q8.16 limits.
// Reset: rst_n clears all valid bits; the pipeline comes up empty.
// Stall: when dout.ready is low the held result stays stable; stages
// behind it keep filling bubbles, and din.ready falls only once every
// stage holds data. Nothing is dropped or repeated.
`default_nettype none
module matrix3_inverse
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    m3i_in_if.sink     din,
    m3i_out_if.source  dout
);
    import m3i_pkg::*;

    q_t   a [9];
    logic f_v;
    div_t f_d;
    logic f_en;

    logic [QB:0] s_v;
    div_t        s_d [QB+1];
    logic [QB:0] s_en;

    assign a[XX] = din.a_xx;
    assign a[XY] = din.a_xy;
    assign a[XZ] = din.a_xz;
    assign a[YX] = din.a_yx;
    assign a[YY] = din.a_yy;
    assign a[YZ] = din.a_yz;
    assign a[ZX] = din.a_zx;
    assign a[ZY] = din.a_zy;
    assign a[ZZ] = din.a_zz;

    m3i_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .v_in   (din.valid),
        .a      (a),
        .en_in  (din.ready),
        .en_out (s_en[0]),
        .v_out  (f_v),
        .d_out  (f_d)
    );

    assign s_v[0] = f_v;
    assign s_d[0] = f_d;

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        m3i_div_stage u_stage
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .v_in   (s_v[i]),
            .d_in   (s_d[i]),
            .en_in  (s_en[i]),
            .en_out (s_en[i+1]),
            .v_out  (s_v[i+1]),
            .d_out  (s_d[i+1])
        );
    end

    m3i_output u_output
    (
        .clk   (clk),
        .rst_n (rst_n),
        .v_in  (s_v[QB]),
        .d_in  (s_d[QB]),
        .en_in (f_en),
        .dout  (dout)
    );

    assign s_en[QB] = f_en;

endmodule
`default_nettype wire

FILE: rtl/m3i_front.sv
// Front pipeline: cofactors, determinant, magnitudes and divider setup.
`default_nettype none
module m3i_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            v_in,
    input  m3i_pkg::q_t          a [9],
    output logic                 en_in,
    input  wire logic            en_out,
    output logic                 v_out,
    output m3i_pkg::div_t        d_out
);
    import m3i_pkg::*;

    logic [FRONT_STAGES-1:0] v_reg;
    logic [FRONT_STAGES-1:0] en;

    q_t                       e1_reg [3];
    logic signed [PROD_W-1:0] p1_reg [18];
    logic signed [PROD_W-1:0] p1_next [18];

    q_t                       e2_reg [3];
    logic signed [COF_W-1:0]  c2_reg [LANES];

    logic signed [COF_W-1:0]  c3_reg [LANES];
    logic signed [PP_W-1:0]   lo3_reg [3];
    logic signed [PP_W-1:0]   hi3_reg [3];

    logic signed [COF_W-1:0]  c4_reg [LANES];
    logic signed [TERM_W-1:0] t4_reg [3];

    logic signed [COF_W-1:0]  c5_reg [LANES];
    logic signed [DET_W-1:0]  d5_reg;

    logic [CMAG_W-1:0]        cm6_reg [LANES];
    logic [LANES-1:0]         neg6_reg;
    logic [LANES-1:0]         cz6_reg;
    logic [MAG_W-1:0]         m6_reg;
    logic                     dz6_reg;
    logic signed [DET_W-1:0]  d_abs;

    logic [NUM_W-1:0]         n7_reg [LANES];
    logic [LANES-1:0]         neg7_reg;
    logic [LANES-1:0]         cz7_reg;
    logic [MAG_W-1:0]         m7_reg;
    logic                     dz7_reg;

    div_t                     d8_reg;
    div_t                     d8_next;

    function automatic logic signed [PROD_W-1:0] pmul(q_t x, q_t y);
        return PROD_W'(x) * PROD_W'(y);
    endfunction

    always_comb
    begin
        en[FRONT_STAGES-1] = !v_reg[FRONT_STAGES-1] || en_out;
        for (int k = FRONT_STAGES - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign en_in = en[0];
    assign v_out = v_reg[FRONT_STAGES-1];
    assign d_out = d8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= v_in;
            for (int k = 1; k < FRONT_STAGES; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // cofactor products, pairs subtract in stage 2
    always_comb
    begin
        p1_next[0]  = pmul(a[YY], a[ZZ]);  p1_next[1]  = pmul(a[YZ], a[ZY]);
        p1_next[2]  = pmul(a[ZY], a[XZ]);  p1_next[3]  = pmul(a[XY], a[ZZ]);
        p1_next[4]  = pmul(a[XY], a[YZ]);  p1_next[5]  = pmul(a[XZ], a[YY]);
        p1_next[6]  = pmul(a[ZX], a[YZ]);  p1_next[7]  = pmul(a[YX], a[ZZ]);
        p1_next[8]  = pmul(a[XX], a[ZZ]);  p1_next[9]  = pmul(a[ZX], a[XZ]);
        p1_next[10] = pmul(a[XZ], a[YX]);  p1_next[11] = pmul(a[XX], a[YZ]);
        p1_next[12] = pmul(a[YX], a[ZY]);  p1_next[13] = pmul(a[ZX], a[YY]);
        p1_next[14] = pmul(a[XY], a[ZX]);  p1_next[15] = pmul(a[XX], a[ZY]);
        p1_next[16] = pmul(a[XX], a[YY]);  p1_next[17] = pmul(a[XY], a[YX]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1_reg[0] <= a[XX];
            e1_reg[1] <= a[YX];
            e1_reg[2] <= a[ZX];
            p1_reg    <= p1_next;
        end
        if (en[1])
        begin
            e2_reg <= e1_reg;
            for (int k = 0; k < LANES; k++)
                c2_reg[k] <= COF_W'(p1_reg[2*k]) - COF_W'(p1_reg[2*k+1]);
        end
        if (en[2])
        begin
            c3_reg <= c2_reg;
            for (int j = 0; j < 3; j++)
            begin
                lo3_reg[j] <= PP_W'(e2_reg[j]) * PP_W'($signed({1'b0, c2_reg[j][LO_W-1:0]}));
                hi3_reg[j] <= PP_W'(e2_reg[j]) * PP_W'($signed(c2_reg[j][COF_W-1:LO_W]));
            end
        end
        if (en[3])
        begin
            c4_reg <= c3_reg;
            for (int j = 0; j < 3; j++)
                t4_reg[j] <= (TERM_W'(hi3_reg[j]) <<< LO_W) + TERM_W'(lo3_reg[j]);
        end
        if (en[4])
        begin
            c5_reg <= c4_reg;
            d5_reg <= DET_W'(t4_reg[0]) + DET_W'(t4_reg[1]) + DET_W'(t4_reg[2]);
        end
        if (en[5])
        begin
            m6_reg  <= MAG_W'(d_abs);
            dz6_reg <= (d5_reg == '0);
            for (int k = 0; k < LANES; k++)
            begin
                cm6_reg[k]  <= CMAG_W'(c5_reg[k][COF_W-1] ? -c5_reg[k] : c5_reg[k]);
                neg6_reg[k] <= c5_reg[k][COF_W-1] ^ d5_reg[DET_W-1];
                cz6_reg[k]  <= (c5_reg[k] == '0);
            end
        end
        if (en[6])
        begin
            m7_reg   <= m6_reg;
            dz7_reg  <= dz6_reg;
            neg7_reg <= neg6_reg;
            cz7_reg  <= cz6_reg;
            for (int k = 0; k < LANES; k++)
                n7_reg[k] <= (NUM_W'(cm6_reg[k]) << FRAC_SH) + NUM_W'(m6_reg);
        end
        if (en[7])
            d8_reg <= d8_next;
    end

    assign d_abs = d5_reg[DET_W-1] ? -d5_reg : d5_reg;

    // numerator already carries the half-divisor rounding term
    always_comb
    begin
        d8_next.den   = {m7_reg, 1'b0};
        d8_next.dzero = dz7_reg;
        for (int k = 0; k < LANES; k++)
        begin
            d8_next.lane[k].big   = (n7_reg[k] >> QB) >= NUM_W'({m7_reg, 1'b0});
            d8_next.lane[k].rem   = DEN_W'(n7_reg[k] >> QB);
            d8_next.lane[k].qw    = n7_reg[k][QB-1:0];
            d8_next.lane[k].neg   = neg7_reg[k];
            d8_next.lane[k].czero = cz7_reg[k];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/m3i_div_stage.sv
// One restoring-division stage: one quotient bit for all nine lanes.
`default_nettype none
module m3i_div_stage
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      v_in,
    input  m3i_pkg::div_t  d_in,
    output logic           en_in,
    input  wire logic      en_out,
    output logic           v_out,
    output m3i_pkg::div_t  d_out
);
    import m3i_pkg::*;

    logic v_reg;
    div_t d_reg;
    div_t d_next;
    logic [DEN_W:0] x;
    logic           take;

    assign en_in = !v_reg || en_out;
    assign v_out = v_reg;
    assign d_out = d_reg;

    always_comb
    begin
        d_next = d_in;
        x      = '0;
        take   = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            x    = {d_in.lane[k].rem, d_in.lane[k].qw[QB-1]};
            take = x >= {1'b0, d_in.den};
            d_next.lane[k].rem = take ? DEN_W'(x - {1'b0, d_in.den}) : DEN_W'(x);
            d_next.lane[k].qw  = {d_in.lane[k].qw[QB-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en_in)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
            d_reg <= d_next;
    end

endmodule
`default_nettype wire

FILE: rtl/m3i_output.sv
// Output stage: sign, saturation, singular flag and the output register.
`default_nettype none
module m3i_output
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      v_in,
    input  m3i_pkg::div_t  d_in,
    output logic           en_in,
    m3i_out_if.source      dout
);
    import m3i_pkg::*;

    logic              v_reg;
    q_t                inv_reg [LANES];
    q_t                inv_next [LANES];
    logic              sing_reg;
    logic              sing_next;
    logic [QB-1:0]     q;

    assign en_in = !v_reg || dout.ready;

    always_comb
    begin
        sing_next = d_in.dzero;
        q         = '0;
        for (int k = 0; k < LANES; k++)
        begin
            q = d_in.lane[k].qw;
            if (d_in.dzero || d_in.lane[k].czero)
                inv_next[k] = '0;
            else if (d_in.lane[k].neg)
            begin
                if (d_in.lane[k].big || q > QB'(Q_MAXNEG))
                begin
                    inv_next[k] = Q_MAXNEG;
                    sing_next   = 1'b1;
                end
                else
                    inv_next[k] = -q[DATA_W-1:0];
            end
            else
            begin
                if (d_in.lane[k].big || q > QB'(Q_MAXPOS))
                begin
                    inv_next[k] = Q_MAXPOS;
                    sing_next   = 1'b1;
                end
                else
                    inv_next[k] = q[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en_in)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            inv_reg  <= inv_next;
            sing_reg <= sing_next;
        end
    end

    assign dout.valid    = v_reg;
    assign dout.inv_xx   = inv_reg[XX];
    assign dout.inv_xy   = inv_reg[XY];
    assign dout.inv_xz   = inv_reg[XZ];
    assign dout.inv_yx   = inv_reg[YX];
    assign dout.inv_yy   = inv_reg[YY];
    assign dout.inv_yz   = inv_reg[YZ];
    assign dout.inv_zx   = inv_reg[ZX];
    assign dout.inv_zy   = inv_reg[ZY];
    assign dout.inv_zz   = inv_reg[ZZ];
    assign dout.singular = sing_reg;

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for matrix3_inverse: directed table plus random matrices.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import m3i_pkg::*;

    localparam int N_RANDOM   = 1930;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN      = 60;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 300;
    localparam logic [DATA_W-1:0] ONE = 24'h010000;

    typedef logic [LANES-1:0][DATA_W-1:0] mat_t;
    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] e;
        logic                         sing;
    } inv_t;
    typedef struct packed {
        logic chk;
        inv_t want;
    } typed_t;
    typedef struct packed {
        mat_t   a;
        typed_t t;
    } row_t;

    logic clk;
    logic rst_n;
    m3i_in_if  din();
    m3i_out_if dout();

    matrix3_inverse u_dut (.clk(clk), .rst_n(rst_n), .din(din), .dout(dout));

    inv_t   inverse_q[$];
    typed_t typed_q[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     out_count = 0;
    bit     done_sending = 0;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
    end

    function automatic logic [127:0] mag128(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic inv_t invert3(mat_t a);
        logic signed [127:0] v[LANES];
        logic signed [127:0] c[LANES];
        logic signed [127:0] d;
        logic [127:0] m, q;
        logic dneg, neg;
        inv_t r;
        for (int k = 0; k < LANES; k++)
            v[k] = $signed(a[k]);
        c[0] = v[YY] * v[ZZ] - v[YZ] * v[ZY];
        c[1] = v[ZY] * v[XZ] - v[XY] * v[ZZ];
        c[2] = v[XY] * v[YZ] - v[XZ] * v[YY];
        c[3] = v[ZX] * v[YZ] - v[YX] * v[ZZ];
        c[4] = v[XX] * v[ZZ] - v[ZX] * v[XZ];
        c[5] = v[XZ] * v[YX] - v[XX] * v[YZ];
        c[6] = v[YX] * v[ZY] - v[ZX] * v[YY];
        c[7] = v[XY] * v[ZX] - v[XX] * v[ZY];
        c[8] = v[XX] * v[YY] - v[XY] * v[YX];
        d = v[XX] * c[0] + v[YX] * c[1] + v[ZX] * c[2];
        r = '0;
        if (d == 0)
        begin
            r.sing = 1'b1;
            return r;
        end
        dneg = d < 0;
        m = mag128(d);
        for (int k = 0; k < LANES; k++)
        begin
            if (c[k] != 0)
            begin
                neg = (c[k] < 0) ^ dneg;
                q = ((mag128(c[k]) << 33) + m) / (m << 1);
                if (neg)
                begin
                    if (q > 128'(Q_MAXNEG))
                    begin
                        q = 128'(Q_MAXNEG);
                        r.sing = 1'b1;
                    end
                    r.e[k] = DATA_W'(-q);
                end
                else
                begin
                    if (q > 128'(Q_MAXPOS))
                    begin
                        q = 128'(Q_MAXPOS);
                        r.sing = 1'b1;
                    end
                    r.e[k] = DATA_W'(q);
                end
            end
        end
        return r;
    endfunction

    function automatic mat_t diag(logic [DATA_W-1:0] x);
        mat_t a;
        a = '0;
        a[XX] = x;
        a[YY] = x;
        a[ZZ] = x;
        return a;
    endfunction

    function automatic logic [DATA_W-1:0] rnd_span(int span);
        return DATA_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic mat_t random_matrix();
        mat_t a;
        int   mode;
        int   s;
        mode = $urandom_range(0, 5);
        for (int k = 0; k < LANES; k++)
            a[k] = DATA_W'($urandom);
        case (mode)
            1: for (int k = 0; k < LANES; k++) a[k] = rnd_span(32'h40000);
            2:
            begin
                for (int k = 0; k < LANES; k++) a[k] = rnd_span(32'h30000);
                s = $urandom_range(0, 3);
                a[ZX] = a[XX] << s;
                a[ZY] = a[XY] << s;
                a[ZZ] = a[XZ] << s;
            end
            3:
            begin
                for (int k = 0; k < LANES; k++) a[k] = rnd_span(32'h4000);
                a[XX] = a[XX] + ONE;
                a[YY] = a[YY] - ONE;
                a[ZZ] = a[ZZ] + (ONE << 1);
            end
            4: for (int k = 0; k < LANES; k++) a[k] = rnd_span(300);
            5: for (int k = 0; k < LANES; k++) a[k] = rnd_span(32'h800);
            default: ;
        endcase
        return a;
    endfunction

    // transfer bookkeeping and checking
    always @(posedge clk)
    begin
        inv_t   got, want;
        typed_t t;
        if (rst_n)
        begin
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (din.valid && din.ready)
            begin
                t = typed_q.pop_front();
                inverse_q.push_back(t.chk ? t.want : invert3({din.a_zz, din.a_zy, din.a_zx,
                    din.a_yz, din.a_yy, din.a_yx, din.a_xz, din.a_xy, din.a_xx}));
            end
            if (dout.valid && dout.ready)
            begin
                got.e = {dout.inv_zz, dout.inv_zy, dout.inv_zx, dout.inv_yz, dout.inv_yy,
                         dout.inv_yx, dout.inv_xz, dout.inv_xy, dout.inv_xx};
                got.sing = dout.singular;
                out_count <= out_count + 1;
                if (inverse_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d with no matrix pending", out_count);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            for (int k = 0; k < LANES; k++)
                                if (got.e[k] !== want.e[k])
                                    $display("result %0d entry %0d: exp %h got %h",
                                             out_count, k, want.e[k], got.e[k]);
                            if (got.sing !== want.sing)
                                $display("result %0d singular: exp %b got %b",
                                         out_count, want.sing, got.sing);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    // sink side: changing stall patterns plus one long hold-off
    initial
    begin
        int cyc;
        int mode;
        dout.ready <= 1'b0;
        mode = 0;
        cyc = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
                dout.ready <= 1'b0;
            else
                case (mode)
                    0: dout.ready <= 1'b1;
                    1: dout.ready <= ($urandom_range(0, 1) == 0);
                    2: dout.ready <= ($urandom_range(0, 4) == 0);
                    default: dout.ready <= ((cyc % 3) != 0);
                endcase
        end
    end

    task automatic drive(mat_t a, typed_t t);
        typed_q.push_back(t);
        din.valid <= 1'b1;
        {din.a_zz, din.a_zy, din.a_zx, din.a_yz, din.a_yy, din.a_yx, din.a_xz, din.a_xy,
         din.a_xx} <= a;
        do
            @(posedge clk);
        while (!din.ready);
    endtask

    // source side
    initial
    begin
        row_t   rows[$];
        row_t   r;
        typed_t none;
        inv_t   w;
        int     burst;
        din.valid <= 1'b0;
        {din.a_zz, din.a_zy, din.a_zx, din.a_yz, din.a_yy, din.a_yx, din.a_xz, din.a_xy,
         din.a_xx} <= '0;
        none = '0;

        w = '0; w.e = diag(ONE);
        r.a = diag(ONE); r.t = {1'b1, w}; rows.push_back(r);
        w = '0; w.sing = 1'b1;
        r.a = '0; r.t = {1'b1, w}; rows.push_back(r);
        r.a = {LANES{Q_MAXPOS}}; rows.push_back(r);
        r.a = {LANES{Q_MAXNEG}}; rows.push_back(r);
        w = '0; w.e = diag(24'h008000);
        r.a = diag(24'h020000); r.t = {1'b1, w}; rows.push_back(r);
        w = '0; w.e = diag(24'hFF0000);
        r.a = diag(24'hFF0000); r.t = {1'b1, w}; rows.push_back(r);
        w = '0; w.e = diag(Q_MAXPOS); w.sing = 1'b1;
        r.a = diag(24'h000001); r.t = {1'b1, w}; rows.push_back(r);
        w = '0; w.e = diag(Q_MAXNEG); w.sing = 1'b1;
        r.a = diag(24'hFFFFFF); r.t = {1'b1, w}; rows.push_back(r);
        r.t = none;
        r.a = diag(Q_MAXPOS); rows.push_back(r);
        r.a = diag(Q_MAXNEG); rows.push_back(r);
        r.a = {24'h0, 24'h0, ONE, 24'h0, ONE, 24'h0, ONE, 24'h0, 24'h0}; rows.push_back(r);
        r.a = {ONE, 24'h020000, 24'h030000, 24'h040000, 24'h050000, 24'h060000,
               24'h070000, 24'h080000, 24'h0A0000}; rows.push_back(r);
        r.a = {Q_MAXPOS, Q_MAXNEG, 24'h0, Q_MAXNEG, Q_MAXPOS, 24'h000001,
               24'h0, 24'hFFFFFF, Q_MAXPOS}; rows.push_back(r);
        r.a = {24'h000100, 24'h0, 24'h0, 24'h0, 24'h000100, 24'h0,
               24'h0, 24'h0, 24'h000100}; rows.push_back(r);
        r.a = {24'h0, ONE, ONE, ONE, 24'h0, ONE, ONE, ONE, 24'h0}; rows.push_back(r);

        @(posedge clk iff rst_n);
        foreach (rows[i])
            drive(rows[i].a, rows[i].t);
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (burst == 0)
            begin
                din.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 30);
            end
            drive(random_matrix(), none);
            burst--;
        end
        din.valid <= 1'b0;
        done_sending = 1;
    end

    initial
    begin
        wait (done_sending);
        wait (inverse_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && inverse_q.size() == 0)
            $display("[matrix3_inverse] OK");
        else
            $display("[matrix3_inverse] ERROR");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("[matrix3_inverse] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/m3i_pkg.sv
rtl/m3i_in_if.sv
rtl/m3i_out_if.sv
rtl/m3i_front.sv
rtl/m3i_div_stage.sv
rtl/m3i_output.sv
rtl/matrix3_inverse.sv
bench/tb.sv
